// File: design/lpcp_pkg.sv
// ----------------------------------------------------------------------------
// lpcp_pkg
// Shared widths, register indexes, reset values and the configuration
// bundle for the lidar point to camera projection pipeline.
// ----------------------------------------------------------------------------
package lpcp_pkg;

   localparam int PIXEL_BITS     = 16;
   localparam int POINT_BITS     = 24;
   localparam int COEF_BITS      = 18;
   localparam int TRANS_BITS     = 20;
   localparam int TRANS_SHIFT    = 16;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 3;

   localparam int PROD_BITS  = COEF_BITS + POINT_BITS;
   localparam int CAM_BITS   = 46;
   localparam int NORM_FRAC  = 16;
   localparam int QUOT_BITS  = 21;
   localparam int NORM_BITS  = QUOT_BITS + 1;
   localparam int DIV_STEPS  = QUOT_BITS;
   localparam int REM_BITS   = CAM_BITS + NORM_FRAC + 5;
   localparam int SAT_BITS   = CAM_BITS + 5;
   localparam logic [QUOT_BITS-1:0] NORM_LIMIT = QUOT_BITS'(1) << (QUOT_BITS - 1);

   localparam int LENS_STAGES = 10;
   localparam int PROJ_BITS   = 58;
   localparam int ROUND_SHIFT = 20;
   localparam int RND_BITS    = PROJ_BITS - ROUND_SHIFT;

   localparam logic [RND_BITS-1:0] PIX_POS_MAX = RND_BITS'((64'd1 << (PIXEL_BITS - 1)) - 1);
   localparam logic [RND_BITS-1:0] PIX_NEG_MAX = RND_BITS'(64'd1 << (PIXEL_BITS - 1));

   localparam logic [53:0] ROT_ROW0_RESET = 54'd65536;
   localparam logic [53:0] ROT_ROW1_RESET = 54'd17179869184;
   localparam logic [53:0] ROT_ROW2_RESET = 54'd4503599627370496;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROT_ROW0   = 3'd0,
      CSR_ROT_ROW1   = 3'd1,
      CSR_ROT_ROW2   = 3'd2,
      CSR_TRANS      = 3'd3,
      CSR_INTRINSICS = 3'd4,
      CSR_DISTORTION = 3'd5,
      CSR_IMAGE_SIZE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [2:0][2:0][COEF_BITS-1:0] rot;
      logic [2:0][TRANS_BITS-1:0]     trans;
      logic [15:0] fx;
      logic [15:0] fy;
      logic [15:0] cx;
      logic [15:0] cy;
      logic [15:0] k1;
      logic [15:0] k2;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [11:0] width;
      logic [11:0] height;
   } cfg_type;

endpackage

// File: design/lpcp_req_if.sv
// ----------------------------------------------------------------------------
// lpcp_req_if
// Point channel: valid/ready with one lidar point per beat.
// ----------------------------------------------------------------------------
interface lpcp_req_if import lpcp_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [POINT_BITS-1:0] point_x;
   logic signed [POINT_BITS-1:0] point_y;
   logic signed [POINT_BITS-1:0] point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface

// File: design/lpcp_rsp_if.sv
// ----------------------------------------------------------------------------
// lpcp_rsp_if
// Pixel channel: valid/ready with one projected pixel per beat.
// ----------------------------------------------------------------------------
interface lpcp_rsp_if import lpcp_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] pixel_u;
   logic signed [PIXEL_BITS-1:0] pixel_v;
   logic                         behind_camera;
   logic                         inside_image;

   modport source (output valid, output pixel_u, output pixel_v,
                   output behind_camera, output inside_image, input ready);
   modport sink   (input valid, input pixel_u, input pixel_v,
                   input behind_camera, input inside_image, output ready);
endinterface

// File: design/lpcp_csr.sv
// ----------------------------------------------------------------------------
// lpcp_csr
// Configuration register file: rotation, translation, intrinsics,
// distortion and image size, unpacked into one bundle.
// ----------------------------------------------------------------------------
module lpcp_csr import lpcp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   output cfg_type                   cfg
);

   logic [53:0] rot_ff [3];
   logic [59:0] trans_ff;
   logic [63:0] intr_ff;
   logic [63:0] dist_ff;
   logic [23:0] size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= ROT_ROW0_RESET;
         rot_ff[1] <= ROT_ROW1_RESET;
         rot_ff[2] <= ROT_ROW2_RESET;
         trans_ff  <= '0;
         intr_ff   <= '0;
         dist_ff   <= '0;
         size_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ROT_ROW0:   rot_ff[0] <= csr_wr_data[53:0];
            CSR_ROT_ROW1:   rot_ff[1] <= csr_wr_data[53:0];
            CSR_ROT_ROW2:   rot_ff[2] <= csr_wr_data[53:0];
            CSR_TRANS:      trans_ff  <= csr_wr_data[59:0];
            CSR_INTRINSICS: intr_ff   <= csr_wr_data;
            CSR_DISTORTION: dist_ff   <= csr_wr_data;
            CSR_IMAGE_SIZE: size_ff   <= csr_wr_data[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cfg.rot[i] = rot_ff[i];
      end
      cfg.trans  = trans_ff;
      cfg.fx     = intr_ff[15:0];
      cfg.fy     = intr_ff[31:16];
      cfg.cx     = intr_ff[47:32];
      cfg.cy     = intr_ff[63:48];
      cfg.k1     = dist_ff[15:0];
      cfg.k2     = dist_ff[31:16];
      cfg.p1     = dist_ff[47:32];
      cfg.p2     = dist_ff[63:48];
      cfg.width  = size_ff[11:0];
      cfg.height = size_ff[23:12];
   end

endmodule

// File: design/lpcp_transform.sv
// ----------------------------------------------------------------------------
// lpcp_transform
// Rigid transform into the camera frame: nine products in one stage,
// row sums plus translation in the next. Result in Q26 meters.
// ----------------------------------------------------------------------------
module lpcp_transform import lpcp_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  cfg_type                      cfg,
   input  logic                         in_valid,
   input  logic signed [POINT_BITS-1:0] point_x,
   input  logic signed [POINT_BITS-1:0] point_y,
   input  logic signed [POINT_BITS-1:0] point_z,
   output logic                         out_valid,
   output logic signed [CAM_BITS-1:0]   cam_x,
   output logic signed [CAM_BITS-1:0]   cam_y,
   output logic signed [CAM_BITS-1:0]   cam_z
);

   logic signed [POINT_BITS-1:0] pnt [3];
   logic signed [PROD_BITS-1:0]  prod_in [3][3];
   logic signed [PROD_BITS-1:0]  prod_ff [3][3];
   logic signed [CAM_BITS-1:0]   cam_in [3];
   logic signed [CAM_BITS-1:0]   cam_ff [3];
   logic                         prod_valid_ff;
   logic                         cam_valid_ff;

   assign pnt[0] = point_x;
   assign pnt[1] = point_y;
   assign pnt[2] = point_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = $signed(cfg.rot[i][j]) * pnt[j];
         end
         cam_in[i] = CAM_BITS'(prod_ff[i][0]) + CAM_BITS'(prod_ff[i][1])
                   + CAM_BITS'(prod_ff[i][2])
                   + (CAM_BITS'($signed(cfg.trans[i])) <<< TRANS_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         cam_valid_ff  <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= in_valid;
         cam_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         cam_ff  <= cam_in;
      end
   end

   assign out_valid = cam_valid_ff;
   assign cam_x     = cam_ff[0];
   assign cam_y     = cam_ff[1];
   assign cam_z     = cam_ff[2];

endmodule

// File: design/lpcp_divide.sv
// ----------------------------------------------------------------------------
// lpcp_divide
// Pipelined restoring divider, two lanes sharing the depth divisor:
// x/z and y/z in Q16, truncated toward zero, limited to +-16.0.
// One quotient bit per stage.
// ----------------------------------------------------------------------------
module lpcp_divide import lpcp_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic signed [CAM_BITS-1:0]  num_x,
   input  logic signed [CAM_BITS-1:0]  num_y,
   input  logic signed [CAM_BITS-1:0]  den,
   input  logic                        behind_in,
   output logic                        out_valid,
   output logic signed [NORM_BITS-1:0] norm_x,
   output logic signed [NORM_BITS-1:0] norm_y,
   output logic                        behind_out
);

   logic [REM_BITS-1:0]        rem_in [DIV_STEPS+1][2];
   logic [REM_BITS-1:0]        rem_ff [DIV_STEPS+1][2];
   logic [QUOT_BITS-1:0]       quo_in [DIV_STEPS+1][2];
   logic [QUOT_BITS-1:0]       quo_ff [DIV_STEPS+1][2];
   logic                       neg_in [DIV_STEPS+1][2];
   logic                       neg_ff [DIV_STEPS+1][2];
   logic                       sat_in [DIV_STEPS+1][2];
   logic                       sat_ff [DIV_STEPS+1][2];
   logic [CAM_BITS-1:0]        den_in [DIV_STEPS+1];
   logic [CAM_BITS-1:0]        den_ff [DIV_STEPS+1];
   logic                       bhd_in [DIV_STEPS+1];
   logic                       bhd_ff [DIV_STEPS+1];
   logic                       valid_ff [DIV_STEPS+1];
   logic signed [NORM_BITS-1:0] norm_in [2];
   logic signed [NORM_BITS-1:0] norm_ff [2];
   logic                       out_bhd_ff;
   logic                       out_valid_ff;
   logic signed [CAM_BITS-1:0] num [2];

   assign num[0] = num_x;
   assign num[1] = num_y;

   always_comb begin
      logic [CAM_BITS-1:0]  mag;
      logic [REM_BITS-1:0]  dsh;
      logic                 qbit;
      logic [QUOT_BITS-1:0] qm;
      den_in[0] = den;
      bhd_in[0] = behind_in;
      for (int l = 0; l < 2; l++) begin
         neg_in[0][l] = num[l][CAM_BITS-1];
         mag = neg_in[0][l] ? CAM_BITS'(-num[l]) : CAM_BITS'(num[l]);
         sat_in[0][l] = SAT_BITS'(mag) >= (SAT_BITS'(den) << 5);
         rem_in[0][l] = REM_BITS'(mag) << NORM_FRAC;
         quo_in[0][l] = '0;
      end
      for (int s = 0; s < DIV_STEPS; s++) begin
         den_in[s+1] = den_ff[s];
         bhd_in[s+1] = bhd_ff[s];
         for (int l = 0; l < 2; l++) begin
            dsh  = REM_BITS'(den_ff[s]) << (DIV_STEPS - 1 - s);
            qbit = rem_ff[s][l] >= dsh;
            rem_in[s+1][l] = qbit ? rem_ff[s][l] - dsh : rem_ff[s][l];
            quo_in[s+1][l] = {quo_ff[s][l][QUOT_BITS-2:0], qbit};
            neg_in[s+1][l] = neg_ff[s][l];
            sat_in[s+1][l] = sat_ff[s][l];
         end
      end
      for (int l = 0; l < 2; l++) begin
         qm = (sat_ff[DIV_STEPS][l] || quo_ff[DIV_STEPS][l] > NORM_LIMIT)
            ? NORM_LIMIT : quo_ff[DIV_STEPS][l];
         norm_in[l] = neg_ff[DIV_STEPS][l] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STEPS; s++) begin
            valid_ff[s] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 0; s < DIV_STEPS; s++) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         out_valid_ff <= valid_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff     <= rem_in;
         quo_ff     <= quo_in;
         neg_ff     <= neg_in;
         sat_ff     <= sat_in;
         den_ff     <= den_in;
         bhd_ff     <= bhd_in;
         norm_ff    <= norm_in;
         out_bhd_ff <= bhd_ff[DIV_STEPS];
      end
   end

   assign out_valid  = out_valid_ff;
   assign norm_x     = norm_ff[0];
   assign norm_y     = norm_ff[1];
   assign behind_out = out_bhd_ff;

endmodule

// File: design/lpcp_lens.sv
// ----------------------------------------------------------------------------
// lpcp_lens
// Brown-Conrady distortion and focal/center intrinsics on normalized
// coordinates, ten stages, two lanes. Result is the pixel position in Q20.
// ----------------------------------------------------------------------------
module lpcp_lens import lpcp_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  cfg_type                      cfg,
   input  logic                         in_valid,
   input  logic signed [NORM_BITS-1:0]  norm_x,
   input  logic signed [NORM_BITS-1:0]  norm_y,
   input  logic                         behind_in,
   output logic                         out_valid,
   output logic signed [PROJ_BITS-1:0]  proj_u,
   output logic signed [PROJ_BITS-1:0]  proj_v,
   output logic                         behind_out
);

   localparam int D16_BITS = 51;
   localparam int DCL_BITS = 38;
   localparam logic signed [D16_BITS-1:0] D_HI = D16_BITS'(64'sd1 <<< 36);
   localparam logic signed [D16_BITS-1:0] D_LO = -D_HI;

   logic signed [NORM_BITS-1:0] nin [2];
   logic [15:0] tcxy [2];
   logic [15:0] tcarg [2];
   logic [15:0] foc [2];
   logic [15:0] ctr [2];

   logic signed [NORM_BITS-1:0] s1_n_ff [2], s2_n_ff [2], s3_n_ff [2], s4_n_ff [2];
   logic signed [NORM_BITS-1:0] s5_n_ff [2];
   logic signed [43:0] s1_sq_ff [2];
   logic signed [43:0] s1_xy_ff;
   logic [25:0]        s2_r2_ff;
   logic [26:0]        s2_arg_ff [2];
   logic signed [27:0] s2_xy16_ff;
   logic [51:0]        s3_r2sq_ff;
   logic signed [42:0] s3_k1r2_ff;
   logic signed [43:0] s3_pxy_ff [2];
   logic signed [43:0] s3_parg_ff [2];
   logic signed [52:0] s4_k2r4_ff;
   logic signed [42:0] s4_k1r2_ff;
   logic signed [45:0] s4_t28_ff [2];
   logic signed [42:0] s5_rad16_ff;
   logic signed [45:0] s5_t28_ff [2];
   logic signed [42:0] s6_pl_ff [2];
   logic signed [44:0] s6_ph_ff [2];
   logic signed [45:0] s6_t28_ff [2];
   logic signed [66:0] s7_d32_ff [2];
   logic signed [DCL_BITS-1:0] s8_d_ff [2];
   logic signed [36:0] s9_fl_ff [2];
   logic signed [35:0] s9_fh_ff [2];
   logic signed [PROJ_BITS-1:0] s10_u_ff [2];
   logic valid_ff [LENS_STAGES];
   logic bhd_ff [LENS_STAGES];

   logic signed [45:0] sum_r;
   logic signed [45:0] sum_a [2];
   logic signed [54:0] rad;
   logic signed [D16_BITS-1:0] d16 [2];

   assign nin[0]   = norm_x;
   assign nin[1]   = norm_y;
   assign tcxy[0]  = cfg.p1;
   assign tcxy[1]  = cfg.p2;
   assign tcarg[0] = cfg.p2;
   assign tcarg[1] = cfg.p1;
   assign foc[0]   = cfg.fx;
   assign foc[1]   = cfg.fy;
   assign ctr[0]   = cfg.cx;
   assign ctr[1]   = cfg.cy;

   always_comb begin
      sum_r = 46'(s1_sq_ff[0]) + 46'(s1_sq_ff[1]);
      for (int l = 0; l < 2; l++) begin
         sum_a[l] = sum_r + (46'(s1_sq_ff[l]) <<< 1);
         d16[l]   = $signed(s7_d32_ff[l][66:16]);
      end
      rad = 55'(64'sd1 <<< 28) + 55'(s4_k1r2_ff) + 55'(s4_k2r4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LENS_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < LENS_STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bhd_ff[0] <= behind_in;
         for (int s = 1; s < LENS_STAGES; s++) begin
            bhd_ff[s] <= bhd_ff[s-1];
         end
         s1_xy_ff    <= nin[0] * nin[1];
         s2_r2_ff    <= sum_r[41:16];
         s2_xy16_ff  <= $signed(s1_xy_ff[43:16]);
         s3_r2sq_ff  <= s2_r2_ff * s2_r2_ff;
         s3_k1r2_ff  <= $signed(cfg.k1) * $signed({1'b0, s2_r2_ff});
         s4_k2r4_ff  <= $signed(cfg.k2) * $signed({1'b0, s3_r2sq_ff[51:16]});
         s4_k1r2_ff  <= s3_k1r2_ff;
         s5_rad16_ff <= $signed(rad[54:12]);
         for (int l = 0; l < 2; l++) begin
            s1_n_ff[l]    <= nin[l];
            s1_sq_ff[l]   <= nin[l] * nin[l];
            s2_n_ff[l]    <= s1_n_ff[l];
            s2_arg_ff[l]  <= sum_a[l][42:16];
            s3_n_ff[l]    <= s2_n_ff[l];
            s3_pxy_ff[l]  <= $signed(tcxy[l]) * s2_xy16_ff;
            s3_parg_ff[l] <= $signed(tcarg[l]) * $signed({1'b0, s2_arg_ff[l]});
            s4_n_ff[l]    <= s3_n_ff[l];
            s4_t28_ff[l]  <= (46'(s3_pxy_ff[l]) <<< 1) + 46'(s3_parg_ff[l]);
            s5_n_ff[l]    <= s4_n_ff[l];
            s5_t28_ff[l]  <= s4_t28_ff[l];
            s6_pl_ff[l]   <= s5_n_ff[l] * $signed({1'b0, s5_rad16_ff[19:0]});
            s6_ph_ff[l]   <= s5_n_ff[l] * $signed(s5_rad16_ff[42:20]);
            s6_t28_ff[l]  <= s5_t28_ff[l];
            s7_d32_ff[l]  <= (67'(s6_ph_ff[l]) <<< 20) + 67'(s6_pl_ff[l])
                           + (67'(s6_t28_ff[l]) <<< 4);
            if (d16[l] > D_HI) begin
               s8_d_ff[l] <= DCL_BITS'(D_HI);
            end else if (d16[l] < D_LO) begin
               s8_d_ff[l] <= DCL_BITS'(D_LO);
            end else begin
               s8_d_ff[l] <= DCL_BITS'(d16[l]);
            end
            s9_fl_ff[l]  <= $signed({1'b0, foc[l]}) * $signed({1'b0, s8_d_ff[l][18:0]});
            s9_fh_ff[l]  <= $signed({1'b0, foc[l]}) * $signed(s8_d_ff[l][37:19]);
            s10_u_ff[l]  <= (PROJ_BITS'(s9_fh_ff[l]) <<< 19) + PROJ_BITS'(s9_fl_ff[l])
                          + (PROJ_BITS'($signed({1'b0, ctr[l]})) <<< 16);
         end
      end
   end

   assign out_valid  = valid_ff[LENS_STAGES-1];
   assign behind_out = bhd_ff[LENS_STAGES-1];
   assign proj_u     = s10_u_ff[0];
   assign proj_v     = s10_u_ff[1];

endmodule

// File: design/lidar_point_camera_projection.sv
// ----------------------------------------------------------------------------
// lidar_point_camera_projection
// Projects one lidar point per beat to a camera pixel. The block takes a
// new point every cycle while the pixel side is not stalled and returns
// one pixel beat per point, in order. A point passes through the rigid
// transform, the depth divider (one quotient bit per stage, 21 bits), lens
// distortion and intrinsics, and a final rounding register. A stall
// on the pixel side freezes the whole pipeline and drops ready on the
// point side. Configuration registers are written through the csr_ port
// and must only change while no point is in flight.
// ----------------------------------------------------------------------------
module lidar_point_camera_projection import lpcp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   lpcp_req_if.sink                  req_bus,
   lpcp_rsp_if.source                rsp_bus,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data
);

   cfg_type                      cfg;
   logic                         advance;
   logic                         xf_valid;
   logic signed [CAM_BITS-1:0]   cam_x, cam_y, cam_z;
   logic                         dv_valid;
   logic signed [NORM_BITS-1:0]  norm_x, norm_y;
   logic                         dv_behind;
   logic                         ln_valid;
   logic signed [PROJ_BITS-1:0]  proj [2];
   logic                         ln_behind;

   logic                         rsp_valid_ff;
   logic signed [PIXEL_BITS-1:0] pix_in [2];
   logic signed [PIXEL_BITS-1:0] pix_ff [2];
   logic                         behind_ff;
   logic                         inside_in;
   logic                         inside_ff;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   lpcp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   lpcp_transform u_transform (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg),
      .in_valid  (req_bus.valid),
      .point_x   (req_bus.point_x),
      .point_y   (req_bus.point_y),
      .point_z   (req_bus.point_z),
      .out_valid (xf_valid),
      .cam_x     (cam_x),
      .cam_y     (cam_y),
      .cam_z     (cam_z)
   );

   lpcp_divide u_divide (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (xf_valid),
      .num_x      (cam_x),
      .num_y      (cam_y),
      .den        (cam_z),
      .behind_in  (cam_z <= 0),
      .out_valid  (dv_valid),
      .norm_x     (norm_x),
      .norm_y     (norm_y),
      .behind_out (dv_behind)
   );

   lpcp_lens u_lens (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .cfg        (cfg),
      .in_valid   (dv_valid),
      .norm_x     (norm_x),
      .norm_y     (norm_y),
      .behind_in  (dv_behind),
      .out_valid  (ln_valid),
      .proj_u     (proj[0]),
      .proj_v     (proj[1]),
      .behind_out (ln_behind)
   );

   always_comb begin
      logic                 neg;
      logic [PROJ_BITS-1:0] mag;
      logic [PROJ_BITS-1:0] rsum;
      logic [RND_BITS-1:0]  rnd;
      for (int l = 0; l < 2; l++) begin
         neg  = proj[l][PROJ_BITS-1];
         mag  = neg ? PROJ_BITS'(-proj[l]) : PROJ_BITS'(proj[l]);
         rsum = mag + (PROJ_BITS'(1) << (ROUND_SHIFT - 1));
         rnd  = rsum[PROJ_BITS-1:ROUND_SHIFT];
         if (ln_behind) begin
            pix_in[l] = '1;
         end else if (!neg) begin
            pix_in[l] = (rnd > PIX_POS_MAX) ? PIXEL_BITS'(PIX_POS_MAX) : PIXEL_BITS'(rnd);
         end else begin
            pix_in[l] = (rnd > PIX_NEG_MAX) ? -PIXEL_BITS'(PIX_NEG_MAX) : -PIXEL_BITS'(rnd);
         end
      end
      inside_in = !ln_behind
                && !pix_in[0][PIXEL_BITS-1] && ($unsigned(pix_in[0]) < PIXEL_BITS'(cfg.width))
                && !pix_in[1][PIXEL_BITS-1] && ($unsigned(pix_in[1]) < PIXEL_BITS'(cfg.height));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ln_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pix_ff    <= pix_in;
         behind_ff <= ln_behind;
         inside_ff <= inside_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.pixel_u       = pix_ff[0];
   assign rsp_bus.pixel_v       = pix_ff[1];
   assign rsp_bus.behind_camera = behind_ff;
   assign rsp_bus.inside_image  = inside_ff;

   a_behind_minus_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && behind_ff |-> pix_ff[0] == '1 && pix_ff[1] == '1 && !inside_ff)
      else $error("behind point without minus one pixel");

   a_inside_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && inside_ff |-> !behind_ff && !pix_ff[0][PIXEL_BITS-1]
                                 && !pix_ff[1][PIXEL_BITS-1])
      else $error("inside flag on negative or behind pixel");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(rsp_valid_ff) && $stable(pix_ff[0]) && $stable(pix_ff[1]))
      else $error("output beat changed during stall");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && advance |=> u_transform.prod_valid_ff)
      else $error("accepted point lost at pipeline entry");

endmodule
